// ===== hw/rtl/dcla_pkg.sv =====
// Shared widths, codes and types for the duty-cycled load-cell averager.
package dcla_pkg;

    // Field and datapath widths.
    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned WEIGHT_W   = 32;
    localparam int unsigned THR_W      = 16;
    localparam int unsigned SCALE_W    = 32;
    localparam int unsigned DIV_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Longest sampling window in ticks.
    localparam int unsigned MAX_WINDOW = 255;

    // Phase codes. The unused code behaves as sampling.
    localparam logic [1:0] PH_SAMPLING = 2'd0;
    localparam logic [1:0] PH_IDLE     = 2'd1;
    localparam logic [1:0] PH_SETTLING = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_THRESHOLD = 3'd5;

    // Saturation bounds of the Q24.8 weight.
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

    // What one tick does to the window, as seen before the state update.
    typedef struct packed {
        logic close_win;  // the window closes on this tick
        logic has_data;   // the closing window holds a valid sample
        logic power_on;   // the phase after this tick is not idle
    } t_seq_stat;

endpackage

// ===== hw/rtl/dcla_div.sv =====
// Radix-2 restoring divider that retires one quotient bit per cycle.
module dcla_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dcla_pkg::DIV_W-1:0]    i_rem0,
    input  logic [dcla_pkg::DIV_W-1:0]    i_dvd,
    input  logic [dcla_pkg::DIV_W-1:0]    i_dsr,
    output logic                          o_done,
    output logic [dcla_pkg::DIV_W-1:0]    o_quo
);

    localparam int unsigned STEP_W = $clog2(dcla_pkg::DIV_W);

    logic [dcla_pkg::DIV_W-1:0] r_rem;
    logic [dcla_pkg::DIV_W-1:0] r_quo;
    logic [dcla_pkg::DIV_W-1:0] r_dsr;
    logic [STEP_W-1:0]          r_step;
    logic                       r_run;
    logic                       r_done;

    logic [dcla_pkg::DIV_W:0]   trial;
    logic [dcla_pkg::DIV_W:0]   trial_sub;
    logic                       fits;
    logic [dcla_pkg::DIV_W-1:0] n_rem;
    logic                       last_step;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    // While the seeded remainder is below the divisor it stays below it, so it fits the register.
    always_comb begin
        trial     = {r_rem, r_quo[dcla_pkg::DIV_W-1]};
        trial_sub = trial - {1'b0, r_dsr};
        fits      = (trial >= {1'b0, r_dsr});
        n_rem     = fits ? trial_sub[dcla_pkg::DIV_W-1:0] : trial[dcla_pkg::DIV_W-1:0];
        last_step = (r_step == STEP_W'(dcla_pkg::DIV_W - 1));
    end

    // Control: run for one step per quotient bit, then pulse done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 1'b1;
                if (last_step) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits leave the top of r_quo as quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_quo <= i_dvd;
            r_dsr <= i_dsr;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[dcla_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hw/rtl/dcla_seq.sv =====
// Phase sequencer and window accumulator: one update per accepted tick.
module dcla_seq #(
    parameter int unsigned MAX_WINDOW = dcla_pkg::MAX_WINDOW
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_step,
    input  logic                                   i_sample_ready,
    input  logic signed [dcla_pkg::SAMPLE_W-1:0]   i_sample_value,
    input  logic [dcla_pkg::CNT_W-1:0]             i_window_ticks,
    input  logic [dcla_pkg::CNT_W-1:0]             i_idle_ticks,
    input  logic [dcla_pkg::CNT_W-1:0]             i_settle_ticks,
    output dcla_pkg::t_seq_stat                    o_stat,
    output logic signed [dcla_pkg::SUM_W-1:0]      o_sum,
    output logic [dcla_pkg::CNT_W-1:0]             o_count
);

    localparam int unsigned WIN_CAP =
        (MAX_WINDOW > 255) ? 255 : MAX_WINDOW;
    localparam logic [dcla_pkg::CNT_W-1:0] CNT_FULL = '1;

    logic [1:0]                          r_phase;
    logic [dcla_pkg::CNT_W-1:0]          r_window_cnt;
    logic [dcla_pkg::CNT_W-1:0]          r_idle_cnt;
    logic [dcla_pkg::CNT_W-1:0]          r_settle_cnt;
    logic signed [dcla_pkg::SUM_W-1:0]   r_sum;
    logic [dcla_pkg::CNT_W-1:0]          r_valid_cnt;

    logic [dcla_pkg::CNT_W-1:0]          win;
    logic                                take;
    logic signed [dcla_pkg::SUM_W-1:0]   n_sum;
    logic [dcla_pkg::CNT_W-1:0]          n_valid_cnt;
    logic [dcla_pkg::CNT_W-1:0]          n_window_cnt;
    logic [dcla_pkg::CNT_W-1:0]          n_idle_cnt;
    logic [dcla_pkg::CNT_W-1:0]          n_settle_cnt;
    logic                                in_idle;
    logic                                in_settle;
    logic                                in_sampling;
    logic                                idle_end;
    logic                                settle_end;
    logic                                close_win;

    // Next counts for every phase; the phase decode picks which one is kept.
    always_comb begin
        win = (i_window_ticks > dcla_pkg::CNT_W'(WIN_CAP)) ?
              dcla_pkg::CNT_W'(WIN_CAP) : i_window_ticks;
        in_idle     = (r_phase == dcla_pkg::PH_IDLE);
        in_settle   = (r_phase == dcla_pkg::PH_SETTLING);
        in_sampling = !in_idle && !in_settle;
        take = i_sample_ready && (i_sample_value != '0) && (r_valid_cnt != CNT_FULL);
        n_sum = r_sum + (take ? dcla_pkg::SUM_W'(i_sample_value) : '0);
        n_valid_cnt  = r_valid_cnt + dcla_pkg::CNT_W'(take);
        n_window_cnt = r_window_cnt + 1'b1;
        n_idle_cnt   = r_idle_cnt + 1'b1;
        n_settle_cnt = r_settle_cnt + 1'b1;
        idle_end     = (n_idle_cnt >= i_idle_ticks);
        settle_end   = (n_settle_cnt >= i_settle_ticks);
        close_win    = in_sampling && (n_window_cnt >= win);
    end

    // Status of the tick as it is accepted.
    always_comb begin
        o_stat.close_win = close_win;
        o_stat.has_data  = (n_valid_cnt != '0);
        o_stat.power_on  = !((in_idle && !idle_end) || close_win);
        o_sum            = n_sum;
        o_count          = n_valid_cnt;
    end

    // State update on each accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= dcla_pkg::PH_SAMPLING;
            r_window_cnt <= '0;
            r_idle_cnt   <= '0;
            r_settle_cnt <= '0;
            r_sum        <= '0;
            r_valid_cnt  <= '0;
        end else if (i_step) begin
            if (in_idle) begin
                r_idle_cnt <= n_idle_cnt;
                if (idle_end) begin
                    r_phase      <= dcla_pkg::PH_SETTLING;
                    r_settle_cnt <= '0;
                end
            end else if (in_settle) begin
                r_settle_cnt <= n_settle_cnt;
                if (settle_end) begin
                    r_phase      <= dcla_pkg::PH_SAMPLING;
                    r_window_cnt <= '0;
                end
            end else if (close_win) begin
                r_sum        <= '0;
                r_valid_cnt  <= '0;
                r_window_cnt <= '0;
                r_phase      <= dcla_pkg::PH_IDLE;
                r_idle_cnt   <= '0;
            end else begin
                r_sum        <= n_sum;
                r_valid_cnt  <= n_valid_cnt;
                r_window_cnt <= n_window_cnt;
            end
        end
    end

endmodule

// ===== hw/rtl/duty_cycled_load_cell_averager_unit.sv =====
// Top level of the duty-cycled load-cell averager: control, divider use and outputs.
//
// Each input transaction is one tick and produces exactly one output transaction.
// A tick that does not close a window with data goes from acceptance to the ST_OUT
// state and then into the output register. A tick that closes a window holding valid
// samples passes through the shared bit-serial divider twice, first for the
// average (sum / count) and then for the Q24.8 weight, with setup and compare
// states around the two divisions. The block takes one tick at a time and holds stall
// high while it works and during reset; a finished result waits in the output
// register, and a new tick is taken while it waits. Configuration is written
// through a plain write port and is taken whenever the write enable is high.
module duty_cycled_load_cell_averager_unit #(
    parameter int unsigned MAX_WINDOW = dcla_pkg::MAX_WINDOW
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // Configuration write port
    input  logic                                        i_cfg_wr_en,
    input  logic [dcla_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [dcla_pkg::CFG_DATA_W-1:0]             i_cfg_data,
    // Tick input channel
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic                                        i_sample_ready,
    input  logic signed [dcla_pkg::SAMPLE_W-1:0]        i_sample_value,
    // Result output channel
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic                                        o_power_on,
    output logic                                        o_window_done,
    output logic                                        o_responding,
    output logic                                        o_weight_stable,
    output logic signed [dcla_pkg::SAMPLE_W-1:0]        o_avg_raw,
    output logic signed [dcla_pkg::WEIGHT_W-1:0]        o_weight
);

    localparam int unsigned SW  = dcla_pkg::SAMPLE_W;
    localparam int unsigned WW  = dcla_pkg::WEIGHT_W;
    localparam int unsigned DW  = dcla_pkg::DIV_W;
    localparam int unsigned MAG_LO = 8;

    // Controller states.
    localparam logic [3:0] ST_READY  = 4'd0;
    localparam logic [3:0] ST_AVG_GO = 4'd1;
    localparam logic [3:0] ST_AVG    = 4'd2;
    localparam logic [3:0] ST_DIFF   = 4'd3;
    localparam logic [3:0] ST_WGT_GO = 4'd4;
    localparam logic [3:0] ST_WGT    = 4'd5;
    localparam logic [3:0] ST_DELTA  = 4'd6;
    localparam logic [3:0] ST_STB    = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    // Configuration registers.
    logic [dcla_pkg::CNT_W-1:0]          r_window_ticks;
    logic [dcla_pkg::CNT_W-1:0]          r_idle_ticks;
    logic [dcla_pkg::CNT_W-1:0]          r_settle_ticks;
    logic signed [SW-1:0]                r_zero_offset;
    logic [dcla_pkg::SCALE_W-1:0]        r_scale_factor;
    logic [dcla_pkg::THR_W-1:0]          r_stable_threshold;

    // Controller and working registers.
    logic [3:0]                          r_state;
    logic signed [dcla_pkg::SUM_W-1:0]   r_sum;
    logic [dcla_pkg::CNT_W-1:0]          r_count;
    logic                                r_neg;
    logic signed [SW-1:0]                r_avg;
    logic signed [SW:0]                  r_diff;
    logic                                r_wsat;
    logic                                r_wzero;
    logic signed [WW-1:0]                r_wnew;
    logic signed [WW:0]                  r_delta;

    // Published state and per-tick flags.
    logic signed [SW-1:0]                r_last_avg;
    logic signed [WW-1:0]                r_last_weight;
    logic                                r_responding;
    logic                                r_stable;
    logic                                r_done;
    logic                                r_power;

    // Output register.
    logic                                r_out_valid;
    logic                                r_o_power_on;
    logic                                r_o_window_done;
    logic                                r_o_responding;
    logic                                r_o_weight_stable;
    logic signed [SW-1:0]                r_o_avg_raw;
    logic signed [WW-1:0]                r_o_weight;

    dcla_pkg::t_seq_stat                 seq_stat;
    logic signed [dcla_pkg::SUM_W-1:0]   seq_sum;
    logic [dcla_pkg::CNT_W-1:0]          seq_count;
    logic                                in_accept;
    logic                                out_free;

    logic                                div_start;
    logic [DW-1:0]                       div_rem0;
    logic [DW-1:0]                       div_dvd;
    logic [DW-1:0]                       div_dsr;
    logic                                div_done;
    logic [DW-1:0]                       div_quo;

    logic [SW:0]                         diff_mag;
    logic signed [SW-1:0]                n_avg;
    logic signed [WW-1:0]                n_wnew;
    logic [WW:0]                         delta_thr;
    logic                                n_stable;

    assign o_in_stall = !i_rst_n || (r_state != ST_READY);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    dcla_seq #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_accept),
        .i_sample_ready (i_sample_ready),
        .i_sample_value (i_sample_value),
        .i_window_ticks (r_window_ticks),
        .i_idle_ticks   (r_idle_ticks),
        .i_settle_ticks (r_settle_ticks),
        .o_stat         (seq_stat),
        .o_sum          (seq_sum),
        .o_count        (seq_count)
    );

    dcla_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem0  (div_rem0),
        .i_dvd   (div_dvd),
        .i_dsr   (div_dsr),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks     <= 8'd19;
            r_idle_ticks       <= 8'd15;
            r_settle_ticks     <= 8'd4;
            r_zero_offset      <= '0;
            r_scale_factor     <= 32'd26214400;
            r_stable_threshold <= 16'd128;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dcla_pkg::CFG_WINDOW_TICKS: begin
                    r_window_ticks <= i_cfg_data[dcla_pkg::CNT_W-1:0];
                end
                dcla_pkg::CFG_IDLE_TICKS: begin
                    r_idle_ticks <= i_cfg_data[dcla_pkg::CNT_W-1:0];
                end
                dcla_pkg::CFG_SETTLE_TICKS: begin
                    r_settle_ticks <= i_cfg_data[dcla_pkg::CNT_W-1:0];
                end
                dcla_pkg::CFG_ZERO_OFFSET: begin
                    r_zero_offset <= i_cfg_data[SW-1:0];
                end
                dcla_pkg::CFG_SCALE_FACTOR: begin
                    r_scale_factor <= i_cfg_data[dcla_pkg::SCALE_W-1:0];
                end
                dcla_pkg::CFG_STABLE_THRESHOLD: begin
                    r_stable_threshold <= i_cfg_data[dcla_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Divider operands. The average divides |sum| by the count. The weight divides
    // |diff| * 2^24 by the scale: the top part |diff| >> 8 seeds the remainder,
    // and the low eight bits of |diff| followed by zeros are shifted in.
    always_comb begin
        diff_mag  = r_diff[SW] ? -r_diff : r_diff;
        div_start = 1'b0;
        div_rem0  = '0;
        div_dvd   = r_sum[dcla_pkg::SUM_W-1] ? DW'(-r_sum) : DW'(r_sum);
        div_dsr   = DW'(r_count);
        if (r_state == ST_AVG_GO) begin
            div_start = 1'b1;
        end else if (r_state == ST_WGT_GO) begin
            div_start = 1'b1;
            div_rem0  = DW'(diff_mag[SW-1:MAG_LO]);
            div_dvd   = {diff_mag[MAG_LO-1:0], (DW - MAG_LO)'(0)};
            div_dsr   = r_scale_factor;
        end
    end

    // Signed results from the divider quotient, and the stability test.
    always_comb begin
        n_avg = r_neg ? -div_quo[SW-1:0] : div_quo[SW-1:0];
        priority if (r_wzero) begin
            n_wnew = '0;
        end else if (r_wsat || div_quo[DW-1]) begin
            n_wnew = r_neg ? dcla_pkg::WEIGHT_MIN : dcla_pkg::WEIGHT_MAX;
        end else begin
            n_wnew = r_neg ? -div_quo[WW-1:0] : div_quo[WW-1:0];
        end
        // A negative change is stable when change + threshold stays above zero.
        delta_thr = r_delta + (WW + 1)'(r_stable_threshold);
        if (r_delta[WW]) begin
            n_stable = !delta_thr[WW] && (delta_thr != '0);
        end else begin
            n_stable = (r_delta < (WW + 1)'(r_stable_threshold));
        end
    end

    // Controller: one tick from acceptance to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_READY;
            r_last_avg    <= '0;
            r_last_weight <= '0;
            r_responding  <= 1'b0;
            r_stable      <= 1'b0;
            r_done        <= 1'b0;
            r_power       <= 1'b1;
        end else begin
            unique case (r_state)
                ST_READY: begin
                    if (in_accept) begin
                        r_power <= seq_stat.power_on;
                        r_done  <= 1'b0;
                        if (seq_stat.close_win && seq_stat.has_data) begin
                            r_state <= ST_AVG_GO;
                        end else begin
                            if (seq_stat.close_win) begin
                                r_responding <= 1'b0;
                                r_stable     <= 1'b0;
                            end
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_AVG_GO: begin
                    r_state <= ST_AVG;
                end
                ST_AVG: begin
                    if (div_done) begin
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_state <= ST_WGT_GO;
                end
                ST_WGT_GO: begin
                    r_state <= ST_WGT;
                end
                ST_WGT: begin
                    if (div_done) begin
                        r_state <= ST_DELTA;
                    end
                end
                ST_DELTA: begin
                    r_state <= ST_STB;
                end
                ST_STB: begin
                    r_stable      <= n_stable;
                    r_last_weight <= r_wnew;
                    r_last_avg    <= r_avg;
                    r_responding  <= 1'b1;
                    r_done        <= 1'b1;
                    r_state       <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_READY;
                    end
                end
                default: begin
                    r_state <= ST_READY;
                end
            endcase
        end
    end

    // Working datapath registers for the closing window.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sum   <= seq_sum;
            r_count <= seq_count;
        end
        if (r_state == ST_AVG_GO) begin
            r_neg <= r_sum[dcla_pkg::SUM_W-1];
        end
        if (r_state == ST_AVG && div_done) begin
            r_avg <= n_avg;
        end
        if (r_state == ST_DIFF) begin
            r_diff <= {r_avg[SW-1], r_avg} - {r_zero_offset[SW-1], r_zero_offset};
        end
        if (r_state == ST_WGT_GO) begin
            r_neg   <= r_diff[SW];
            r_wzero <= (r_diff == '0);
            r_wsat  <= (DW'(diff_mag[SW-1:MAG_LO]) >= r_scale_factor);
        end
        if (r_state == ST_WGT && div_done) begin
            r_wnew <= n_wnew;
        end
        if (r_state == ST_DELTA) begin
            r_delta <= {r_wnew[WW-1], r_wnew} - {r_last_weight[WW-1], r_last_weight};
        end
    end

    // Output register: loaded when the slot is empty or being emptied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_o_power_on      <= r_power;
            r_o_window_done   <= r_done;
            r_o_responding    <= r_responding;
            r_o_weight_stable <= r_stable;
            r_o_avg_raw       <= r_last_avg;
            r_o_weight        <= r_last_weight;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_power_on      = r_o_power_on;
    assign o_window_done   = r_o_window_done;
    assign o_responding    = r_o_responding;
    assign o_weight_stable = r_o_weight_stable;
    assign o_avg_raw       = r_o_avg_raw;
    assign o_weight        = r_o_weight;

endmodule
